FILE: rtl/gar_pkg.sv
package gar_pkg;

    // Grid geometry: an 8 x 8 map, cells indexed row-major as {row, column}.
    localparam int GRID_DIM   = 8;
    localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
    localparam int CELL_BITS  = 6;
    localparam int COORD_BITS = 3;

    // Search limits.
    localparam int            RESULT_CAP = 63;
    localparam logic [16:0]   F_CEILING  = 17'd50000;
    localparam logic [15:0]   COST_SAT   = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [2:0] REG_GRID_WIDTH      = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_COST_STRAIGHT   = 3'd2;
    localparam logic [2:0] REG_COST_DIAGONAL   = 3'd3;
    localparam logic [2:0] REG_EXPANSION_LIMIT = 3'd4;

    // Request function codes.
    localparam logic FUNC_MAP_WRITE = 1'b0;
    localparam logic FUNC_ROUTE     = 1'b1;

    // Result status codes.
    localparam logic STATUS_STEP     = 1'b0;
    localparam logic STATUS_NO_ROUTE = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CELL_BITS-1:0]  cell_t;
    typedef logic [15:0]           cost_t;

    // One entry of the per-cell search memory. The next field links each route
    // cell to the one after it, from the start toward the goal.
    typedef struct packed {
        logic  open;
        logic  closed;
        cell_t parent;
        cell_t next;
        cost_t g;
        cost_t h;
    } srch_entry_t;

    localparam int SRCH_BITS = $bits(srch_entry_t);

endpackage

FILE: rtl/gar_ram.sv
module gar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/grid_astar_route_finder_top.sv
// Grid route finder: A* search over an 8 x 8 eight-connected map.
// Input channel (in_valid / in_stall): a request with func = 0 writes one map
// cell. A request with func = 1 searches a route from
// (cell_x, cell_y) to (goal_x, goal_y); in_stall stays high until the last
// result of that route has been handed to the output register.
// Output channel (out_valid / out_stall): one result per route cell from the
// step after the start up to the goal, or a single no-route result; last
// marks the final one. A start equal to the goal gives no result when it is
// inside the grid and walkable and the expansion limit is nonzero. A route
// first clears the search memory, then checks the start, the goal and, for
// a blocked goal, the cell below it. Each expansion reads every neighbor
// inside the grid, then a lowest-cost scan over every grid cell in use picks
// the next cell. Tracing reads back from the goal to the start, and each
// result is read once more before it is emitted. The single read port of the
// search memory serialises these reads. Each cell is expanded at most once.
// After reset the block clears its memories and marks every cell walkable;
// in_stall is high meanwhile. Config writes are taken at any time. A stalled
// output holds its result and the sequencer waits.
module grid_astar_route_finder_top
    import gar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [2:0] cell_x,
    input  logic [2:0] cell_y,
    input  logic       blocked,
    input  logic [2:0] goal_x,
    input  logic [2:0] goal_y,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] step_x,
    output logic [2:0] step_y,
    output logic       status,
    output logic       last
);

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_CHK_START,
        ST_CHK_START_D,
        ST_CHK_GOAL_D,
        ST_CHK_BELOW_D,
        ST_EX_RD,
        ST_EX_CAP,
        ST_NB_SEL,
        ST_NB_R0,
        ST_NB_R1,
        ST_NB_R2,
        ST_NB_UPD,
        ST_EX_CLOSE,
        ST_PK_RUN,
        ST_PK_LAST,
        ST_TR_RD,
        ST_TR_CAP,
        ST_EM_RD,
        ST_EM_OUT,
        ST_FAIL
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [3:0] grid_width_reg;
    logic [3:0] grid_height_reg;
    logic [7:0] cost_straight_reg;
    logic [7:0] cost_diagonal_reg;
    logic [7:0] expansion_limit_reg;

    // Request and search registers.
    coord_t      start_x_reg, start_y_reg;
    coord_t      goal_x_reg, goal_y_reg;
    coord_t      cur_x_reg, cur_y_reg;
    srch_entry_t cur_entry_reg;
    srch_entry_t nbr_entry_reg;
    logic [3:0]  nb_reg;
    coord_t      nx_reg, ny_reg;
    logic        diag_reg;
    logic        w0_reg, w1_reg;
    logic        goal_hit_reg;
    logic [7:0]  q_reg;
    coord_t      scan_x_reg, scan_y_reg;
    logic        pend_v_reg;
    coord_t      pend_x_reg, pend_y_reg;
    logic [16:0] best_reg;
    logic        found_reg;
    coord_t      best_x_reg, best_y_reg;
    cell_t       trace_cell_reg;
    cell_t       child_reg;
    cell_t       emit_cell_reg;
    logic [6:0]  trace_n_reg;
    logic [5:0]  emit_k_reg;
    cell_t       clr_cnt_reg;

    // Output register.
    logic   out_valid_reg;
    coord_t step_x_reg, step_y_reg;
    logic   status_reg, last_reg;

    // Memory ports.
    logic        map_wr_en, map_wr_data, map_rd_en, map_rd_data;
    cell_t       map_wr_addr, map_rd_addr;
    logic        srch_wr_en, srch_rd_en;
    cell_t       srch_wr_addr, srch_rd_addr;
    srch_entry_t srch_wr_data, srch_rd_data;

    // Grid size in use, clamped to 1..8.
    logic [3:0] eff_w, eff_h;

    always_comb
    begin
        eff_w = (grid_width_reg == 4'd0) ? 4'd1 :
                (grid_width_reg > 4'(GRID_DIM)) ? 4'(GRID_DIM) : grid_width_reg;
        eff_h = (grid_height_reg == 4'd0) ? 4'd1 :
                (grid_height_reg > 4'(GRID_DIM)) ? 4'(GRID_DIM) : grid_height_reg;
    end

    // Neighbor offset for the current neighbor counter.
    logic signed [1:0] dx, dy;
    logic signed [4:0] nx_wide, ny_wide;
    logic              nb_in_grid;

    always_comb
    begin
        case (nb_reg)
            4'd0:    begin dx = -2'sd1; dy = -2'sd1; end
            4'd1:    begin dx = -2'sd1; dy =  2'sd0; end
            4'd2:    begin dx = -2'sd1; dy =  2'sd1; end
            4'd3:    begin dx =  2'sd0; dy = -2'sd1; end
            4'd5:    begin dx =  2'sd0; dy =  2'sd1; end
            4'd6:    begin dx =  2'sd1; dy = -2'sd1; end
            4'd7:    begin dx =  2'sd1; dy =  2'sd0; end
            4'd8:    begin dx =  2'sd1; dy =  2'sd1; end
            default: begin dx =  2'sd0; dy =  2'sd0; end
        endcase
        nx_wide = $signed({2'b00, cur_x_reg}) + $signed({{3{dx[1]}}, dx});
        ny_wide = $signed({2'b00, cur_y_reg}) + $signed({{3{dy[1]}}, dy});
        nb_in_grid = !nx_wide[4] && (nx_wide[3:0] < eff_w) &&
                     !ny_wide[4] && (ny_wide[3:0] < eff_h);
    end

    // Neighbor update: new g cost, heuristic and the rewritten entry.
    logic [7:0]  step_cost;
    logic [16:0] ng_wide;
    cost_t       ng;
    coord_t      hdx, hdy;
    logic [3:0]  hsum;
    logic [11:0] hval;
    logic        nb_ok;
    srch_entry_t nbr_new;

    always_comb
    begin
        step_cost = diag_reg ? cost_diagonal_reg : cost_straight_reg;
        ng_wide   = {1'b0, cur_entry_reg.g} + {9'd0, step_cost};
        ng        = ng_wide[16] ? COST_SAT : ng_wide[15:0];
        hdx       = (goal_x_reg > nx_reg) ? goal_x_reg - nx_reg : nx_reg - goal_x_reg;
        hdy       = (goal_y_reg > ny_reg) ? goal_y_reg - ny_reg : ny_reg - goal_y_reg;
        hsum      = {1'b0, hdx} + {1'b0, hdy};
        hval      = hsum * cost_straight_reg;
        nb_ok     = (!diag_reg || (w0_reg && w1_reg)) && map_rd_data &&
                    !nbr_entry_reg.closed;
        nbr_new   = nbr_entry_reg;
        if (!nbr_entry_reg.open || (ng < nbr_entry_reg.g))
        begin
            nbr_new.parent = {cur_y_reg, cur_x_reg};
            nbr_new.g      = ng;
        end
        nbr_new.open = 1'b1;
        nbr_new.h    = {4'd0, hval};
    end

    // Lowest-cost scan: candidate from the entry read in the previous cycle.
    logic [16:0] pk_f;
    logic        pk_cand;
    logic        scan_y_end, scan_x_end;

    always_comb
    begin
        pk_f       = {1'b0, srch_rd_data.g} + {1'b0, srch_rd_data.h};
        pk_cand    = pend_v_reg && srch_rd_data.open && (pk_f < best_reg) && (pk_f != 17'd0);
        scan_y_end = ({1'b0, scan_y_reg} == eff_h - 4'd1);
        scan_x_end = ({1'b0, scan_x_reg} == eff_w - 4'd1);
    end

    // Route output bookkeeping.
    logic [5:0] emit_cnt;
    logic       out_free;
    logic       out_load;
    logic       in_accept;

    always_comb
    begin
        emit_cnt  = (trace_n_reg >= 7'(RESULT_CAP)) ? 6'(RESULT_CAP) : trace_n_reg[5:0];
        out_free  = !out_valid_reg || !out_stall;
        out_load  = out_free && (state_reg inside {ST_EM_OUT, ST_FAIL});
        in_accept = in_valid && (state_reg == ST_IDLE);
    end

    // Memory port control by state.
    always_comb
    begin
        map_wr_en     = 1'b0;
        map_wr_addr   = clr_cnt_reg;
        map_wr_data   = 1'b1;
        map_rd_en     = 1'b0;
        map_rd_addr   = {start_y_reg, start_x_reg};
        srch_wr_en    = 1'b0;
        srch_wr_addr  = clr_cnt_reg;
        srch_wr_data  = '0;
        srch_rd_en    = 1'b0;
        srch_rd_addr  = {cur_y_reg, cur_x_reg};
        case (state_reg)
            ST_INIT:
            begin
                map_wr_en  = 1'b1;
                srch_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                map_wr_en   = in_accept && (func == FUNC_MAP_WRITE);
                map_wr_addr = {cell_y, cell_x};
                map_wr_data = !blocked;
            end
            ST_CLR:
            begin
                srch_wr_en = 1'b1;
            end
            ST_CHK_START:
            begin
                map_rd_en = 1'b1;
            end
            ST_CHK_START_D:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = {goal_y_reg, goal_x_reg};
            end
            ST_CHK_GOAL_D:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = {goal_y_reg + 3'd1, goal_x_reg};
            end
            ST_EX_RD:
            begin
                srch_rd_en = 1'b1;
            end
            ST_NB_R0:
            begin
                map_rd_en    = 1'b1;
                map_rd_addr  = {ny_reg, cur_x_reg};
                srch_rd_en   = 1'b1;
                srch_rd_addr = {ny_reg, nx_reg};
            end
            ST_NB_R1:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = {cur_y_reg, nx_reg};
            end
            ST_NB_R2:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = {ny_reg, nx_reg};
            end
            ST_NB_UPD:
            begin
                srch_wr_en   = nb_ok;
                srch_wr_addr = {ny_reg, nx_reg};
                srch_wr_data = nbr_new;
            end
            ST_EX_CLOSE:
            begin
                srch_wr_en          = 1'b1;
                srch_wr_addr        = {cur_y_reg, cur_x_reg};
                srch_wr_data        = cur_entry_reg;
                srch_wr_data.open   = 1'b0;
                srch_wr_data.closed = 1'b1;
            end
            ST_PK_RUN:
            begin
                srch_rd_en   = 1'b1;
                srch_rd_addr = {scan_y_reg, scan_x_reg};
            end
            ST_TR_RD:
            begin
                srch_rd_en   = 1'b1;
                srch_rd_addr = trace_cell_reg;
            end
            ST_TR_CAP:
            begin
                // Link the parent just read to the cell traced before it.
                srch_wr_en        = (trace_n_reg != 7'd0);
                srch_wr_addr      = trace_cell_reg;
                srch_wr_data      = srch_rd_data;
                srch_wr_data.next = child_reg;
            end
            ST_EM_RD:
            begin
                srch_rd_en   = 1'b1;
                srch_rd_addr = emit_cell_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_INIT;
            grid_width_reg      <= 4'd8;
            grid_height_reg     <= 4'd8;
            cost_straight_reg   <= 8'd10;
            cost_diagonal_reg   <= 8'd14;
            expansion_limit_reg <= 8'd200;
            clr_cnt_reg         <= '0;
            out_valid_reg       <= 1'b0;
            nb_reg              <= '0;
            q_reg               <= '0;
            pend_v_reg          <= 1'b0;
            found_reg           <= 1'b0;
            goal_hit_reg        <= 1'b0;
            trace_n_reg         <= '0;
            emit_k_reg          <= '0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:      grid_width_reg      <= cfg_data[3:0];
                    REG_GRID_HEIGHT:     grid_height_reg     <= cfg_data[3:0];
                    REG_COST_STRAIGHT:   cost_straight_reg   <= cfg_data;
                    REG_COST_DIAGONAL:   cost_diagonal_reg   <= cfg_data;
                    REG_EXPANSION_LIMIT: expansion_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // The downstream side takes the waiting result and nothing new is loaded.
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 6'd1;
                    if (clr_cnt_reg == 6'(CELL_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept && (func == FUNC_ROUTE))
                    begin
                        start_x_reg <= cell_x;
                        start_y_reg <= cell_y;
                        goal_x_reg  <= goal_x;
                        goal_y_reg  <= goal_y;
                        clr_cnt_reg <= '0;
                        state_reg   <= ST_CLR;
                    end
                end
                ST_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 6'd1;
                    if (clr_cnt_reg == 6'(CELL_COUNT - 1))
                    begin
                        state_reg <= ST_CHK_START;
                    end
                end
                ST_CHK_START:
                begin
                    if (({1'b0, start_x_reg} >= eff_w) || ({1'b0, start_y_reg} >= eff_h))
                    begin
                        state_reg <= ST_FAIL;
                    end
                    else
                    begin
                        state_reg <= ST_CHK_START_D;
                    end
                end
                ST_CHK_START_D:
                begin
                    if (!map_rd_data || ({1'b0, goal_x_reg} >= eff_w) ||
                        ({1'b0, goal_y_reg} >= eff_h))
                    begin
                        state_reg <= ST_FAIL;
                    end
                    else
                    begin
                        state_reg <= ST_CHK_GOAL_D;
                    end
                end
                ST_CHK_GOAL_D:
                begin
                    cur_x_reg    <= start_x_reg;
                    cur_y_reg    <= start_y_reg;
                    q_reg        <= '0;
                    goal_hit_reg <= 1'b0;
                    if (map_rd_data)
                    begin
                        state_reg <= (expansion_limit_reg == 8'd0) ? ST_FAIL : ST_EX_RD;
                    end
                    else if ({1'b0, goal_y_reg} + 4'd1 < eff_h)
                    begin
                        state_reg <= ST_CHK_BELOW_D;
                    end
                    else
                    begin
                        state_reg <= ST_FAIL;
                    end
                end
                ST_CHK_BELOW_D:
                begin
                    if (map_rd_data && (expansion_limit_reg != 8'd0))
                    begin
                        goal_y_reg <= goal_y_reg + 3'd1;
                        state_reg  <= ST_EX_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FAIL;
                    end
                end
                ST_EX_RD:
                begin
                    state_reg <= ST_EX_CAP;
                end
                ST_EX_CAP:
                begin
                    cur_entry_reg <= srch_rd_data;
                    nb_reg        <= '0;
                    state_reg     <= ST_NB_SEL;
                end
                ST_NB_SEL:
                begin
                    if (nb_reg == 4'd9)
                    begin
                        state_reg <= ST_EX_CLOSE;
                    end
                    else if ((nb_reg == 4'd4) || !nb_in_grid)
                    begin
                        nb_reg <= nb_reg + 4'd1;
                    end
                    else
                    begin
                        nx_reg    <= nx_wide[2:0];
                        ny_reg    <= ny_wide[2:0];
                        diag_reg  <= (dx != 2'sd0) && (dy != 2'sd0);
                        state_reg <= ST_NB_R0;
                    end
                end
                ST_NB_R0:
                begin
                    state_reg <= ST_NB_R1;
                end
                ST_NB_R1:
                begin
                    w0_reg        <= map_rd_data;
                    nbr_entry_reg <= srch_rd_data;
                    state_reg     <= ST_NB_R2;
                end
                ST_NB_R2:
                begin
                    w1_reg    <= map_rd_data;
                    state_reg <= ST_NB_UPD;
                end
                ST_NB_UPD:
                begin
                    if (nb_ok && (nx_reg == goal_x_reg) && (ny_reg == goal_y_reg))
                    begin
                        goal_hit_reg <= 1'b1;
                    end
                    nb_reg    <= nb_reg + 4'd1;
                    state_reg <= ST_NB_SEL;
                end
                ST_EX_CLOSE:
                begin
                    trace_cell_reg <= {goal_y_reg, goal_x_reg};
                    trace_n_reg    <= '0;
                    scan_x_reg     <= '0;
                    scan_y_reg     <= '0;
                    pend_v_reg     <= 1'b0;
                    best_reg       <= F_CEILING;
                    found_reg      <= 1'b0;
                    q_reg          <= q_reg + 8'd1;
                    if (goal_hit_reg || ((cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg)))
                    begin
                        state_reg <= ST_TR_RD;
                    end
                    else if (q_reg + 8'd1 == expansion_limit_reg)
                    begin
                        state_reg <= ST_FAIL;
                    end
                    else
                    begin
                        state_reg <= ST_PK_RUN;
                    end
                end
                ST_PK_RUN:
                begin
                    if (pk_cand)
                    begin
                        best_reg   <= pk_f;
                        best_x_reg <= pend_x_reg;
                        best_y_reg <= pend_y_reg;
                        found_reg  <= 1'b1;
                    end
                    pend_v_reg <= 1'b1;
                    pend_x_reg <= scan_x_reg;
                    pend_y_reg <= scan_y_reg;
                    if (scan_y_end)
                    begin
                        scan_y_reg <= '0;
                        scan_x_reg <= scan_x_reg + 3'd1;
                        if (scan_x_end)
                        begin
                            state_reg <= ST_PK_LAST;
                        end
                    end
                    else
                    begin
                        scan_y_reg <= scan_y_reg + 3'd1;
                    end
                end
                ST_PK_LAST:
                begin
                    goal_hit_reg <= 1'b0;
                    if (pk_cand)
                    begin
                        cur_x_reg <= pend_x_reg;
                        cur_y_reg <= pend_y_reg;
                        state_reg <= ST_EX_RD;
                    end
                    else if (found_reg)
                    begin
                        cur_x_reg <= best_x_reg;
                        cur_y_reg <= best_y_reg;
                        state_reg <= ST_EX_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FAIL;
                    end
                end
                ST_TR_RD:
                begin
                    state_reg <= ST_TR_CAP;
                end
                ST_TR_CAP:
                begin
                    // Walk toward the start; the route is read back from the start.
                    child_reg      <= trace_cell_reg;
                    trace_cell_reg <= srch_rd_data.parent;
                    emit_k_reg     <= '0;
                    emit_cell_reg  <= {start_y_reg, start_x_reg};
                    if (trace_cell_reg == {start_y_reg, start_x_reg})
                    begin
                        state_reg <= (trace_n_reg == 7'd0) ? ST_IDLE : ST_EM_RD;
                    end
                    else
                    begin
                        trace_n_reg <= trace_n_reg + 7'd1;
                        state_reg   <= ST_TR_RD;
                    end
                end
                ST_EM_RD:
                begin
                    state_reg <= ST_EM_OUT;
                end
                ST_EM_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        step_x_reg    <= srch_rd_data.next[2:0];
                        step_y_reg    <= srch_rd_data.next[5:3];
                        status_reg    <= STATUS_STEP;
                        last_reg      <= (emit_k_reg + 6'd1 == emit_cnt);
                        emit_k_reg    <= emit_k_reg + 6'd1;
                        emit_cell_reg <= srch_rd_data.next;
                        state_reg     <= (emit_k_reg + 6'd1 == emit_cnt) ? ST_IDLE : ST_EM_RD;
                    end
                end
                ST_FAIL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        step_x_reg    <= '0;
                        step_y_reg    <= '0;
                        status_reg    <= STATUS_NO_ROUTE;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign step_x    = step_x_reg;
    assign step_y    = step_y_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Walkable map: one bit per cell.
    gar_ram #(
        .WIDTH (1),
        .DEPTH (CELL_COUNT)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    // Per-cell search state: marks, parent, route link and costs.
    gar_ram #(
        .WIDTH (SRCH_BITS),
        .DEPTH (CELL_COUNT)
    ) u_srch_ram (
        .clk     (clk),
        .wr_en   (srch_wr_en),
        .wr_addr (srch_wr_addr),
        .wr_data (srch_wr_data),
        .rd_en   (srch_rd_en),
        .rd_addr (srch_rd_addr),
        .rd_data (srch_rd_data)
    );

endmodule

FILE: sim/tb_grid_astar_route_finder_top.sv
`timescale 1ns / 1ps

module tb_grid_astar_route_finder_top;
    import gar_pkg::*;

    // Step record: one route cell or a no-route marker.
    typedef struct packed {
        logic [2:0] sx;
        logic [2:0] sy;
        logic       st;
        logic       lst;
    } route_step_t;

    // Directed request row; has_exp marks rows whose result is typed in.
    typedef struct packed {
        logic        fn;
        logic [2:0]  cx;
        logic [2:0]  cy;
        logic        blk;
        logic [2:0]  gx;
        logic [2:0]  gy;
        logic        has_exp;
        route_step_t exp_step;
    } req_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       func;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       blocked;
    logic [2:0] goal_x;
    logic [2:0] goal_y;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic       status;
    logic       last;

    grid_astar_route_finder_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .cell_x(cell_x), .cell_y(cell_y), .blocked(blocked),
        .goal_x(goal_x), .goal_y(goal_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .step_x(step_x), .step_y(step_y), .status(status), .last(last)
    );

    // Shadow state of the route finder.
    logic        map_open [CELL_COUNT];
    logic        in_open  [CELL_COUNT];
    logic        in_closed[CELL_COUNT];
    int          from_cell[CELL_COUNT];
    int unsigned g_of     [CELL_COUNT];
    int unsigned h_of     [CELL_COUNT];
    int unsigned cfg_w, cfg_h, cfg_cs, cfg_cd, cfg_lim;
    int          span_w, span_h, tgt_x, tgt_y;

    route_step_t pending_steps[$];
    int          errors;
    int          steps_seen;
    int          routes_sent;
    bit          idle_free;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int idx(input int x, input int y);
        return y * GRID_DIM + x;
    endfunction

    // Open every neighbor step from a cell under expansion, then close the cell.
    function automatic void expand_from(input int ci, input int cj);
        int cur;
        int x;
        int y;
        int n;
        int unsigned ng;
        int unsigned hv;
        cur = idx(ci, cj);
        for (int dx = -1; dx <= 1; dx++)
        begin
            for (int dy = -1; dy <= 1; dy++)
            begin
                x = ci + dx;
                y = cj + dy;
                if (dx == 0 && dy == 0) continue;
                if (x < 0 || x >= span_w || y < 0 || y >= span_h) continue;
                // Corner cutting is not allowed past a blocked side cell.
                if (dx != 0 && dy != 0)
                    if (!map_open[idx(ci, y)] || !map_open[idx(x, cj)]) continue;
                n = idx(x, y);
                if (!map_open[n] || in_closed[n]) continue;
                ng = g_of[cur] + ((dx != 0 && dy != 0) ? cfg_cd : cfg_cs);
                if (ng > 65535) ng = 65535;
                if (in_open[n])
                begin
                    if (ng < g_of[n])
                    begin
                        from_cell[n] = cur;
                        g_of[n] = ng;
                    end
                end
                else
                begin
                    from_cell[n] = cur;
                    g_of[n] = ng;
                    in_open[n] = 1'b1;
                end
                hv = ((tgt_x > x ? tgt_x - x : x - tgt_x) +
                      (tgt_y > y ? tgt_y - y : y - tgt_y)) * cfg_cs;
                if (hv > 65535) hv = 65535;
                h_of[n] = hv;
            end
        end
        in_open[cur] = 1'b0;
        in_closed[cur] = 1'b1;
    endfunction

    // Lowest nonzero f below the ceiling, columns outer, rows inner.
    function automatic bit pick_next(inout int px, inout int py);
        int unsigned best;
        int unsigned f;
        bit found;
        best = 50000;
        found = 1'b0;
        for (int x = 0; x < span_w; x++)
            for (int y = 0; y < span_h; y++)
            begin
                if (!in_open[idx(x, y)]) continue;
                f = g_of[idx(x, y)] + h_of[idx(x, y)];
                if (f < best && f > 0)
                begin
                    best = f;
                    px = x;
                    py = y;
                    found = 1'b1;
                end
            end
        return found;
    endfunction

    function automatic bit search_route(input int sx, input int sy);
        int cx;
        int cy;
        int goal;
        cx = sx;
        cy = sy;
        if (sx >= span_w || sy >= span_h || !map_open[idx(sx, sy)]) return 1'b0;
        if (tgt_x >= span_w || tgt_y >= span_h) return 1'b0;
        if (!map_open[idx(tgt_x, tgt_y)])
        begin
            if (tgt_y + 1 < span_h && map_open[idx(tgt_x, tgt_y + 1)])
                tgt_y++;
            else
                return 1'b0;
        end
        goal = idx(tgt_x, tgt_y);
        for (int q = 0; q < cfg_lim; q++)
        begin
            if (q > 0 && !pick_next(cx, cy)) return 1'b0;
            expand_from(cx, cy);
            if (idx(cx, cy) == goal || in_open[goal]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow state and queue the route it yields.
    function automatic void predict_route(input req_row_t r);
        int start;
        int c;
        int n;
        int emit;
        int path[$];
        route_step_t s;
        if (r.fn == FUNC_MAP_WRITE)
        begin
            map_open[idx(int'(r.cx), int'(r.cy))] = !r.blk;
            return;
        end
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            in_open[i] = 1'b0;
            in_closed[i] = 1'b0;
            g_of[i] = 0;
            h_of[i] = 0;
        end
        span_w = (cfg_w == 0) ? 1 : (cfg_w > GRID_DIM ? GRID_DIM : cfg_w);
        span_h = (cfg_h == 0) ? 1 : (cfg_h > GRID_DIM ? GRID_DIM : cfg_h);
        tgt_x = int'(r.gx);
        tgt_y = int'(r.gy);
        if (!search_route(int'(r.cx), int'(r.cy)))
        begin
            s.sx = 3'd0;
            s.sy = 3'd0;
            s.st = STATUS_NO_ROUTE;
            s.lst = 1'b1;
            pending_steps = {pending_steps, s};
            return;
        end
        start = idx(int'(r.cx), int'(r.cy));
        c = idx(tgt_x, tgt_y);
        n = 0;
        while (c != start && n < CELL_COUNT)
        begin
            path.push_front(c);
            c = from_cell[c] % CELL_COUNT;
            n++;
        end
        emit = (n < RESULT_CAP) ? n : RESULT_CAP;
        for (int k = 0; k < emit; k++)
        begin
            s.sx = 3'(path[k] % GRID_DIM);
            s.sy = 3'(path[k] / GRID_DIM);
            s.st = STATUS_STEP;
            s.lst = (k == emit - 1);
            pending_steps = {pending_steps, s};
        end
    endfunction

    // Register write, only while the block is idle.
    task automatic write_reg(input logic [2:0] r, input logic [7:0] v);
        @(posedge clk);
        while (pending_steps.size() != 0 || in_stall) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            REG_GRID_WIDTH:      cfg_w = v[3:0];
            REG_GRID_HEIGHT:     cfg_h = v[3:0];
            REG_COST_STRAIGHT:   cfg_cs = v;
            REG_COST_DIAGONAL:   cfg_cd = v;
            REG_EXPANSION_LIMIT: cfg_lim = v;
            default: ;
        endcase
    endtask

    // Send one request and hold it until accepted; valid idles at random.
    task automatic send_request(input req_row_t r);
        while (!idle_free && $urandom_range(99) < 10)
        begin
            @(posedge clk);
            in_valid <= 1'b0;
        end
        @(posedge clk);
        in_valid <= 1'b1;
        func <= r.fn;
        cell_x <= r.cx;
        cell_y <= r.cy;
        blocked <= r.blk;
        goal_x <= r.gx;
        goal_y <= r.gy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
        if (r.has_exp && r.fn == FUNC_ROUTE)
            pending_steps = {pending_steps, r.exp_step};
        else
            predict_route(r);
        if (r.fn == FUNC_ROUTE) routes_sent++;
    endtask

    // Wait until every expected result has come, plus a settle margin.
    task automatic drain;
        int guard;
        guard = 0;
        while (pending_steps.size() != 0 && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    // Receiver: random stall and in-order compare.
    always @(posedge clk)
    begin
        route_step_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= (!idle_free && $urandom_range(99) < 10);
            if (out_valid && !out_stall)
            begin
                steps_seen++;
                if (pending_steps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d st=%0d last=%0d",
                             $time, step_x, step_y, status, last);
                end
                else
                begin
                    want = pending_steps.pop_front();
                    if (want.sx !== step_x || want.sy !== step_y ||
                        want.st !== status || want.lst !== last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected x=%0d y=%0d st=%0d last=%0d",
                                 $time, want.sx, want.sy, want.st, want.lst);
                        $display("%0t:          actual   x=%0d y=%0d st=%0d last=%0d",
                                 $time, step_x, step_y, status, last);
                    end
                end
            end
        end
    end

    function automatic req_row_t mk(input logic fn, input int cx, input int cy,
                                    input logic blk, input int gx, input int gy);
        req_row_t r;
        r = '0;
        r.fn = fn;
        r.cx = 3'(cx);
        r.cy = 3'(cy);
        r.blk = blk;
        r.gx = 3'(gx);
        r.gy = 3'(gy);
        return r;
    endfunction

    function automatic req_row_t mk_no_route(input int cx, input int cy,
                                             input int gx, input int gy);
        req_row_t r;
        r = mk(FUNC_ROUTE, cx, cy, 1'b0, gx, gy);
        r.has_exp = 1'b1;
        r.exp_step.st = STATUS_NO_ROUTE;
        r.exp_step.lst = 1'b1;
        return r;
    endfunction

    // Random request; mostly route requests on a lightly blocked map.
    function automatic req_row_t rand_req();
        logic fn;
        fn = ($urandom_range(99) < 55) ? FUNC_ROUTE : FUNC_MAP_WRITE;
        return mk(fn, $urandom_range(7), $urandom_range(7),
                  ($urandom_range(99) < 35), $urandom_range(7), $urandom_range(7));
    endfunction

    req_row_t table_rows[$];

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        cell_x = '0;
        cell_y = '0;
        blocked = 1'b0;
        goal_x = '0;
        goal_y = '0;
        errors = 0;
        steps_seen = 0;
        routes_sent = 0;
        idle_free = 1'b0;
        cfg_w = 8;
        cfg_h = 8;
        cfg_cs = 10;
        cfg_cd = 14;
        cfg_lim = 200;
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            map_open[i] = 1'b1;
            from_cell[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, blocked goal fallback, corner cutting.
        table_rows = {table_rows, mk(FUNC_ROUTE, 0, 0, 1'b0, 7, 7)};
        table_rows = {table_rows, mk(FUNC_ROUTE, 7, 7, 1'b0, 0, 0)};
        table_rows = {table_rows, mk(FUNC_ROUTE, 3, 3, 1'b0, 3, 3)};
        table_rows = {table_rows, mk(FUNC_MAP_WRITE, 4, 4, 1'b1, 0, 0)};
        table_rows = {table_rows, mk(FUNC_ROUTE, 0, 4, 1'b1, 4, 4)};
        table_rows = {table_rows, mk(FUNC_MAP_WRITE, 4, 5, 1'b1, 0, 0)};
        table_rows = {table_rows, mk_no_route(0, 4, 4, 4)};
        table_rows = {table_rows, mk_no_route(4, 5, 0, 0)};
        table_rows = {table_rows, mk(FUNC_MAP_WRITE, 1, 0, 1'b1, 0, 0)};
        table_rows = {table_rows, mk(FUNC_ROUTE, 0, 0, 1'b0, 1, 1)};
        table_rows = {table_rows, mk(FUNC_MAP_WRITE, 4, 7, 1'b1, 0, 0)};
        table_rows = {table_rows, mk_no_route(0, 0, 4, 7)};
        for (int i = 0; i < table_rows.size(); i++) send_request(table_rows[i]);
        drain();

        // Small grid, extreme costs, and a dead end that traps the start.
        write_reg(REG_GRID_WIDTH, 8'd3);
        write_reg(REG_GRID_HEIGHT, 8'd0);
        write_reg(REG_COST_STRAIGHT, 8'd255);
        write_reg(REG_COST_DIAGONAL, 8'd1);
        send_request(mk_no_route(0, 0, 3, 0));
        send_request(mk(FUNC_ROUTE, 0, 0, 1'b0, 2, 0));
        write_reg(REG_GRID_WIDTH, 8'd15);
        write_reg(REG_GRID_HEIGHT, 8'd8);
        write_reg(REG_EXPANSION_LIMIT, 8'd0);
        send_request(mk_no_route(0, 0, 6, 6));
        write_reg(REG_EXPANSION_LIMIT, 8'd1);
        send_request(mk(FUNC_ROUTE, 2, 2, 1'b0, 3, 3));
        send_request(mk(FUNC_ROUTE, 0, 0, 1'b0, 7, 5));
        drain();

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_GRID_WIDTH, (ph == 5) ? 8'd8 : 8'($urandom_range(1, 8)));
            write_reg(REG_GRID_HEIGHT, (ph == 5) ? 8'd8 : 8'($urandom_range(1, 8)));
            write_reg(REG_COST_STRAIGHT, (ph == 0) ? 8'd1 : 8'($urandom_range(1, 255)));
            write_reg(REG_COST_DIAGONAL, (ph == 0) ? 8'd255 : 8'($urandom_range(1, 255)));
            write_reg(REG_EXPANSION_LIMIT, (ph == 5) ? 8'd255 : 8'($urandom_range(1, 80)));
            idle_free = (ph == 3);
            for (int i = 0; i < 50; i++) send_request(rand_req());
            drain();
        end
        idle_free = 1'b0;

        $display("tb: %0d route requests sent, %0d results checked, over six settings",
                 routes_sent, steps_seen);
        if (errors == 0 && pending_steps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: grid_astar_route_finder_top.f
rtl/gar_pkg.sv
rtl/gar_ram.sv
rtl/grid_astar_route_finder_top.sv
sim/tb_grid_astar_route_finder_top.sv
